// File: rtl/core/text_cursor_glyph_renderer_macros.svh
// Assertion macros used by the glyph renderer datapath RTL.
`ifndef TEXT_CURSOR_GLYPH_RENDERER_MACROS_SVH
`define TEXT_CURSOR_GLYPH_RENDERER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define TCGR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define TCGR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TCGR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define TCGR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/core/tcgr_pkg.sv
// Package: field widths, codes, defaults and control types of the glyph renderer.
`timescale 1ns / 1ps

package tcgr_pkg;

  // Payload field widths
  localparam int ACTION_W = 1;
  localparam int CODE_W   = 8;
  localparam int COLOR_W  = 8;
  localparam int FADDR_W  = 12;
  localparam int FBYTE_W  = 8;
  localparam int ADDR_W   = 19;

  // Configuration register widths
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int PITCH_W  = 10;
  localparam int PDATA_W  = 32;
  localparam int PADDR_W  = 4;
  localparam int REGIDX_W = 2;

  // Parameter defaults
  localparam int GLYPH_ROWS_DEF  = 16;
  localparam int CELL_WIDTH_DEF  = 9;
  localparam int FONT_GLYPHS_DEF = 256;

  // Register reset values
  localparam logic [COL_W-1:0]   COLUMNS_RST    = 7'd71;
  localparam logic [ROW_W-1:0]   ROWS_RST       = 5'd30;
  localparam logic [PITCH_W-1:0] LINE_PITCH_RST = 10'd800;

  // Register indexes
  localparam logic [REGIDX_W-1:0] REG_COLUMNS    = 2'd0;
  localparam logic [REGIDX_W-1:0] REG_ROWS       = 2'd1;
  localparam logic [REGIDX_W-1:0] REG_LINE_PITCH = 2'd2;

  // Codes
  localparam logic [ACTION_W-1:0] ACT_CHAR   = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_FONT   = 1'b1;
  localparam logic [CODE_W-1:0]   CH_NEWLINE = 8'd10;
  localparam logic [CODE_W-1:0]   CH_RETURN  = 8'd13;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_DRAW
  } tcgr_state_e;

  // Controller to datapath
  typedef struct packed {
    logic font_wr;
    logic latch;
    logic setup;
    logic emit;
    logic newline;
    logic cret;
    logic advance;
  } tcgr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_font;
    logic is_nl;
    logic is_cr;
    logic row_last;
    logic out_free;
  } tcgr_stat_t;

endpackage

// File: rtl/core/tcgr_if.sv
// Handshake interfaces: character/font input words and framebuffer row words.
`timescale 1ns / 1ps

interface tcgr_char_if;
  logic                           valid;
  logic                           ready;
  logic [tcgr_pkg::ACTION_W-1:0]  action;
  logic [tcgr_pkg::CODE_W-1:0]    char_code;
  logic [tcgr_pkg::COLOR_W-1:0]   pixel_color;
  logic [tcgr_pkg::FADDR_W-1:0]   font_address;
  logic [tcgr_pkg::FBYTE_W-1:0]   font_byte;

  modport source (output valid, action, char_code, pixel_color, font_address, font_byte,
                  input ready);
  modport sink   (input valid, action, char_code, pixel_color, font_address, font_byte,
                  output ready);
endinterface

interface tcgr_row_if;
  logic                          valid;
  logic                          ready;
  logic [tcgr_pkg::ADDR_W-1:0]   pixel_address;
  logic [tcgr_pkg::FBYTE_W-1:0]  glyph_bits;
  logic [tcgr_pkg::COLOR_W-1:0]  write_color;
  logic                          last_of_glyph;

  modport source (output valid, pixel_address, glyph_bits, write_color, last_of_glyph,
                  input ready);
  modport sink   (input valid, pixel_address, glyph_bits, write_color, last_of_glyph,
                  output ready);
endinterface

// File: rtl/core/tcgr_ctrl.sv
// Controller: sequences font writes, cursor moves and the GLYPH_ROWS row writes of a glyph.
`timescale 1ns / 1ps

module tcgr_ctrl import tcgr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  tcgr_stat_t stat_i,
  output tcgr_cmd_t  cmd_o
);

  tcgr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (stat_i.is_font) begin
            cmd_o.font_wr = 1'b1;
          end else if (stat_i.is_nl) begin
            cmd_o.newline = 1'b1;
          end else if (stat_i.is_cr) begin
            cmd_o.cret = 1'b1;
          end else begin
            cmd_o.latch = 1'b1;
            state_d     = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = S_DRAW;
      end
      S_DRAW: begin
        // one row word per cycle while the output register is free
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.row_last) begin
            cmd_o.advance = 1'b1;
            state_d       = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/tcgr_dp.sv
// Datapath: cursor, font memory, row address accumulator and output register.
`timescale 1ns / 1ps

`include "text_cursor_glyph_renderer_macros.svh"

module tcgr_dp import tcgr_pkg::*; #(
  parameter int GLYPH_ROWS  = GLYPH_ROWS_DEF,
  parameter int CELL_WIDTH  = CELL_WIDTH_DEF,
  parameter int FONT_GLYPHS = FONT_GLYPHS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcgr_cmd_t           cmd_i,
  output tcgr_stat_t          stat_o,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [CODE_W-1:0]   char_code_i,
  input  logic [COLOR_W-1:0]  pixel_color_i,
  input  logic [FADDR_W-1:0]  font_address_i,
  input  logic [FBYTE_W-1:0]  font_byte_i,
  input  logic [COL_W-1:0]    columns_i,
  input  logic [ROW_W-1:0]    rows_i,
  input  logic [PITCH_W-1:0]  line_pitch_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [ADDR_W-1:0]   pixel_address_o,
  output logic [FBYTE_W-1:0]  glyph_bits_o,
  output logic [COLOR_W-1:0]  write_color_o,
  output logic                last_of_glyph_o
);

  localparam int FONT_DEPTH = FONT_GLYPHS * GLYPH_ROWS;
  localparam int FAW        = $clog2(FONT_DEPTH);
  localparam int GW         = $clog2(FONT_GLYPHS);
  localparam int RW         = $clog2(GLYPH_ROWS);
  localparam int LW         = ROW_W + RW;
  localparam int XW         = COL_W + $clog2(CELL_WIDTH);

  logic [FBYTE_W-1:0] font_mem [FONT_DEPTH];

  logic [COL_W-1:0]   col_q;
  logic [ROW_W-1:0]   row_q;
  logic [RW-1:0]      r_q;
  logic               out_valid_q;

  logic [COLOR_W-1:0] color_q;
  logic [FAW-1:0]     glyph_base_q;
  logic [LW-1:0]      line0_q;
  logic [XW-1:0]      basex_q;
  logic [ADDR_W-1:0]  run_addr_q;
  logic [ADDR_W-1:0]  out_addr_q;
  logic [FBYTE_W-1:0] out_glyph_q;
  logic [COLOR_W-1:0] out_color_q;
  logic               out_last_q;

  logic [CODE_W:0]    code_ext;
  logic [CODE_W:0]    glyph_full;
  logic [GW-1:0]      glyph;
  logic [FAW-1:0]     glyph_base_d;
  logic [FAW-1:0]     rd_idx;
  logic               font_we;
  logic               row_last;
  logic               out_free;

  logic [COL_W-1:0]   eff_cols;
  logic [ROW_W-1:0]   eff_rows;
  logic [ROW_W-1:0]   last_row;
  logic [ROW_W-1:0]   row_next;
  logic [COL_W:0]     col_inc;
  logic               col_wrap;

  // glyph index is the code modulo the font size; code < 2*FONT_GLYPHS
  assign code_ext     = {1'b0, char_code_i};
  assign glyph_full   = (code_ext >= (CODE_W+1)'(FONT_GLYPHS)) ?
                        code_ext - (CODE_W+1)'(FONT_GLYPHS) : code_ext;
  assign glyph        = glyph_full[GW-1:0];
  assign glyph_base_d = FAW'(glyph) * FAW'(GLYPH_ROWS);
  assign rd_idx       = glyph_base_q + FAW'(r_q);

  assign font_we  = cmd_i.font_wr &&
                    ({1'b0, font_address_i} < (FADDR_W+1)'(FONT_DEPTH));
  assign row_last = (r_q == RW'(GLYPH_ROWS - 1));
  assign out_free = !out_valid_q || out_ready_i;

  assign stat_o.is_font  = (action_i == ACT_FONT);
  assign stat_o.is_nl    = (char_code_i == CH_NEWLINE);
  assign stat_o.is_cr    = (char_code_i == CH_RETURN);
  assign stat_o.row_last = row_last;
  assign stat_o.out_free = out_free;

  // zero limits act as one
  assign eff_cols = (columns_i == '0) ? COL_W'(1) : columns_i;
  assign eff_rows = (rows_i == '0) ? ROW_W'(1) : rows_i;
  assign last_row = eff_rows - ROW_W'(1);
  assign row_next = (row_q >= last_row) ? last_row : row_q + ROW_W'(1);
  assign col_inc  = {1'b0, col_q} + (COL_W+1)'(1);
  assign col_wrap = (col_inc >= {1'b0, eff_cols});

  // font memory, registered read straight into the output register
  always_ff @(posedge clk_i) begin
    if (font_we) begin
      font_mem[font_address_i[FAW-1:0]] <= font_byte_i;
    end
    if (cmd_i.emit) begin
      out_glyph_q <= font_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      color_q      <= pixel_color_i;
      glyph_base_q <= glyph_base_d;
      line0_q      <= LW'(row_q) * LW'(GLYPH_ROWS);
      basex_q      <= XW'(col_q) * XW'(CELL_WIDTH);
    end
    if (cmd_i.setup) begin
      run_addr_q <= ADDR_W'(line0_q) * ADDR_W'(line_pitch_i) + ADDR_W'(basex_q);
    end else if (cmd_i.emit) begin
      run_addr_q <= run_addr_q + ADDR_W'(line_pitch_i);
    end
    if (cmd_i.emit) begin
      out_addr_q  <= run_addr_q;
      out_color_q <= color_q;
      out_last_q  <= row_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      r_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.setup) begin
        r_q <= '0;
      end else if (cmd_i.emit) begin
        r_q <= r_q + RW'(1);
      end

      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cmd_i.newline) begin
        col_q <= '0;
        row_q <= row_next;
      end else if (cmd_i.cret) begin
        col_q <= '0;
      end else if (cmd_i.advance) begin
        if (col_wrap) begin
          col_q <= '0;
          row_q <= row_next;
        end else begin
          col_q <= col_inc[COL_W-1:0];
        end
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_address_o = out_addr_q;
  assign glyph_bits_o    = out_glyph_q;
  assign write_color_o   = out_color_q;
  assign last_of_glyph_o = out_last_q;

  `TCGR_ASSERT_IMPL(a_emit_free, clk_i, rst_ni, cmd_i.emit, out_free, "row word overwrote a held word")
  `TCGR_ASSERT_IMPL(a_adv_last, clk_i, rst_ni, cmd_i.advance, cmd_i.emit && row_last, "cursor moved before last row")
  `TCGR_ASSERT_NEXT(a_last_flag, clk_i, rst_ni, cmd_i.emit && row_last, out_valid_q && out_last_q, "last row word not flagged")

endmodule

// File: rtl/core/text_cursor_glyph_renderer.sv
// Top level: text renderer with APB register block, controller and datapath.
//
// Channels: char_i takes one word per valid/ready handshake. action 0 puts a
// character at the cursor, action 1 writes font_byte to the font memory at
// font_address. row_o delivers framebuffer row words: start address, eight
// glyph bits, color, and last_of_glyph on the final row of a character.
// Registers columns, rows and line_pitch sit on the APB port at 0x0, 0x4, 0x8;
// write them only while the block is idle.
// Sequence: font writes, newline and carriage return are taken while idle and
// emit nothing. A printable character is latched, its start address is formed
// in the setup state (row-base multiply), then one row word per cycle goes out
// while the output register is free, as the font memory read port fetches each
// glyph row; the first word passes the setup state and the output register.
// char_i.ready stays low while a character is being drawn.
// The output register holds a word until row_o.ready; a stalled receiver
// stops the row sequence, and char_i may accept the next word while the last
// row word of a character still waits.
// Reset clears the cursor to column 0, row 0 and loads the register defaults.
// The font memory is not cleared; load glyphs before drawing them.
`timescale 1ns / 1ps

module text_cursor_glyph_renderer import tcgr_pkg::*; #(
  parameter int GLYPH_ROWS  = GLYPH_ROWS_DEF,
  parameter int CELL_WIDTH  = CELL_WIDTH_DEF,
  parameter int FONT_GLYPHS = FONT_GLYPHS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  tcgr_char_if.sink          char_i,
  tcgr_row_if.source         row_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [COL_W-1:0]    columns_q;
  logic [ROW_W-1:0]    rows_q;
  logic [PITCH_W-1:0]  line_pitch_q;
  logic [REGIDX_W-1:0] reg_idx;
  logic                reg_wr;

  tcgr_cmd_t  cmd;
  tcgr_stat_t stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q    <= COLUMNS_RST;
      rows_q       <= ROWS_RST;
      line_pitch_q <= LINE_PITCH_RST;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_COLUMNS:    columns_q    <= pwdata[COL_W-1:0];
        REG_ROWS:       rows_q       <= pwdata[ROW_W-1:0];
        REG_LINE_PITCH: line_pitch_q <= pwdata[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_COLUMNS:    prdata = PDATA_W'(columns_q);
      REG_ROWS:       prdata = PDATA_W'(rows_q);
      REG_LINE_PITCH: prdata = PDATA_W'(line_pitch_q);
      default:        prdata = '0;
    endcase
  end

  tcgr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (char_i.valid),
    .in_ready_o (char_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tcgr_dp #(
    .GLYPH_ROWS  (GLYPH_ROWS),
    .CELL_WIDTH  (CELL_WIDTH),
    .FONT_GLYPHS (FONT_GLYPHS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .action_i        (char_i.action),
    .char_code_i     (char_i.char_code),
    .pixel_color_i   (char_i.pixel_color),
    .font_address_i  (char_i.font_address),
    .font_byte_i     (char_i.font_byte),
    .columns_i       (columns_q),
    .rows_i          (rows_q),
    .line_pitch_i    (line_pitch_q),
    .out_ready_i     (row_o.ready),
    .out_valid_o     (row_o.valid),
    .pixel_address_o (row_o.pixel_address),
    .glyph_bits_o    (row_o.glyph_bits),
    .write_color_o   (row_o.write_color),
    .last_of_glyph_o (row_o.last_of_glyph)
  );

endmodule

// File: tb/sv/text_cursor_glyph_renderer_test.sv
// Self-checking bench for the glyph renderer: font loads, text cursor and row words.
`timescale 1ns / 1ps

module text_cursor_glyph_renderer_test;
  import tcgr_pkg::*;

  localparam int FONT_DEPTH  = GLYPH_ROWS_DEF * FONT_GLYPHS_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int PAUSE       = GLYPH_ROWS_DEF + 4;

  typedef struct {
    logic [ACTION_W-1:0] action;
    logic [CODE_W-1:0]   code;
    logic [COLOR_W-1:0]  color;
    logic [FADDR_W-1:0]  faddr;
    logic [FBYTE_W-1:0]  fbyte;
  } char_word_t;

  typedef struct {
    logic [ADDR_W-1:0]  addr;
    logic [FBYTE_W-1:0] bits;
    logic [COLOR_W-1:0] color;
    logic               last;
  } row_word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  tcgr_char_if char_bus ();
  tcgr_row_if  row_bus ();

  text_cursor_glyph_renderer uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_bus),
    .row_o   (row_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state
  logic [COL_W-1:0]   cursor_col  = '0;
  logic [ROW_W-1:0]   cursor_row  = '0;
  logic [COL_W-1:0]   cfg_columns = COLUMNS_RST;
  logic [ROW_W-1:0]   cfg_rows    = ROWS_RST;
  logic [PITCH_W-1:0] cfg_pitch   = LINE_PITCH_RST;
  logic [FBYTE_W-1:0] glyph_store [FONT_DEPTH];
  row_word_t          rows_due [$];

  // Stimulus side
  char_word_t         words_todo [$];
  bit                 in_pool [FONT_GLYPHS_DEF];
  logic [CODE_W-1:0]  glyph_pool [$];
  int                 idle_pct = 0;
  int                 stall_pct = 0;
  bit                 stall_kick = 1'b0;
  bit                 kick_seen = 1'b0;
  int                 hold_left = 0;
  logic               word_taken = 1'b0;
  int                 mismatches = 0;

  task automatic note_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic int at_least_one(input int v);
    return (v == 0) ? 1 : v;
  endfunction

  task automatic next_text_row();
    int last;
    last = at_least_one(cfg_rows) - 1;
    if (int'(cursor_row) >= last) begin
      cursor_row = ROW_W'(last);
    end else begin
      cursor_row = cursor_row + ROW_W'(1);
    end
  endtask

  task automatic render_word(input char_word_t w);
    row_word_t e;
    int        glyph;
    int        line;
    if (w.action == ACT_FONT) begin
      if (int'(w.faddr) < FONT_DEPTH) glyph_store[w.faddr] = w.fbyte;
    end else if (w.code == CH_NEWLINE) begin
      cursor_col = '0;
      next_text_row();
    end else if (w.code == CH_RETURN) begin
      cursor_col = '0;
    end else begin
      glyph = int'(w.code) % FONT_GLYPHS_DEF;
      for (int r = 0; r < GLYPH_ROWS_DEF; r++) begin
        line    = int'(cursor_row) * GLYPH_ROWS_DEF + r;
        e.addr  = ADDR_W'(line * int'(cfg_pitch) + int'(cursor_col) * CELL_WIDTH_DEF);
        e.bits  = glyph_store[glyph * GLYPH_ROWS_DEF + r];
        e.color = w.color;
        e.last  = (r == GLYPH_ROWS_DEF - 1);
        rows_due.push_back(e);
      end
      if (int'(cursor_col) + 1 >= at_least_one(cfg_columns)) begin
        cursor_col = '0;
        next_text_row();
      end else begin
        cursor_col = cursor_col + COL_W'(1);
      end
    end
  endtask

  // Check row words, then predict from the char word taken at the same edge
  always @(posedge clk_i) begin : score
    row_word_t  want;
    char_word_t got;
    if (!rst_ni) begin
      word_taken <= 1'b0;
    end else begin
      if (row_bus.valid && row_bus.ready) begin
        if (rows_due.size() == 0) begin
          note_mismatch("row word with none expected", row_bus.pixel_address, 0);
        end else begin
          want = rows_due.pop_front();
          if (row_bus.pixel_address !== want.addr)
            note_mismatch("pixel_address", row_bus.pixel_address, want.addr);
          if (row_bus.glyph_bits !== want.bits)
            note_mismatch("glyph_bits", row_bus.glyph_bits, want.bits);
          if (row_bus.write_color !== want.color)
            note_mismatch("write_color", row_bus.write_color, want.color);
          if (row_bus.last_of_glyph !== want.last)
            note_mismatch("last_of_glyph", row_bus.last_of_glyph, want.last);
        end
      end
      word_taken <= char_bus.valid && char_bus.ready;
      if (char_bus.valid && char_bus.ready) begin
        got.action = char_bus.action;
        got.code   = char_bus.char_code;
        got.color  = char_bus.pixel_color;
        got.faddr  = char_bus.font_address;
        got.fbyte  = char_bus.font_byte;
        render_word(got);
      end
    end
  end

  always @(negedge clk_i) begin : drive
    char_word_t w;
    if (!rst_ni) begin
      char_bus.valid <= 1'b0;
    end else if (!char_bus.valid || word_taken) begin
      if (words_todo.size() != 0 && $urandom_range(99) >= idle_pct) begin
        w = words_todo.pop_front();
        char_bus.valid        <= 1'b1;
        char_bus.action       <= w.action;
        char_bus.char_code    <= w.code;
        char_bus.pixel_color  <= w.color;
        char_bus.font_address <= w.faddr;
        char_bus.font_byte    <= w.fbyte;
      end else begin
        char_bus.valid <= 1'b0;
      end
    end
  end

  // A toggle of stall_kick starts a long hold-off
  always @(negedge clk_i) begin
    if (stall_kick != kick_seen) begin
      kick_seen     <= stall_kick;
      hold_left     <= HOLD_CYCLES;
      row_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      row_bus.ready <= 1'b0;
    end else begin
      row_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic queue_font(input logic [FADDR_W-1:0] addr, input logic [FBYTE_W-1:0] data);
    char_word_t w;
    w.action = ACT_FONT;
    w.code   = CODE_W'($urandom);
    w.color  = COLOR_W'($urandom);
    w.faddr  = addr;
    w.fbyte  = data;
    words_todo.push_back(w);
  endtask

  task automatic queue_char(input logic [CODE_W-1:0] code, input logic [COLOR_W-1:0] color);
    char_word_t w;
    w.action = ACT_CHAR;
    w.code   = code;
    w.color  = color;
    w.faddr  = FADDR_W'($urandom);
    w.fbyte  = FBYTE_W'($urandom);
    words_todo.push_back(w);
  endtask

  // Full glyph; rows are often all-ones or all-zeros
  task automatic load_glyph(input logic [CODE_W-1:0] code);
    logic [FBYTE_W-1:0] data;
    for (int r = 0; r < GLYPH_ROWS_DEF; r++) begin
      data = ($urandom_range(3) == 0) ? {FBYTE_W{r[0]}} : FBYTE_W'($urandom);
      queue_font(FADDR_W'(int'(code) * GLYPH_ROWS_DEF + r), data);
    end
    if (!in_pool[code]) begin
      in_pool[code] = 1'b1;
      glyph_pool.push_back(code);
    end
  endtask

  // Mostly text drawn from loaded glyphs, with occasional glyph loads; some stray font bytes and controls
  task automatic queue_random(input int n);
    int                made;
    int                pick;
    logic [CODE_W-1:0] code;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      if (glyph_pool.size() == 0 || pick < 4) begin
        do code = CODE_W'($urandom); while (code == CH_NEWLINE || code == CH_RETURN);
        load_glyph(code);
        made += GLYPH_ROWS_DEF;
      end else if (pick < 9) begin
        queue_font(FADDR_W'($urandom), FBYTE_W'($urandom));
        made++;
      end else if (pick < 19) begin
        queue_char((pick < 14) ? CH_NEWLINE : CH_RETURN, COLOR_W'($urandom));
        made++;
      end else begin
        queue_char(glyph_pool[$urandom_range(glyph_pool.size() - 1)], COLOR_W'($urandom));
        made++;
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (words_todo.size() != 0 || char_bus.valid);
    do @(negedge clk_i); while (rows_due.size() != 0);
    // font, newline and return words leave no trace on row_o
    repeat (PAUSE) @(negedge clk_i);
  endtask

  task automatic reg_write(input logic [REGIDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] seen;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_COLUMNS:    cfg_columns = value[COL_W-1:0];
      REG_ROWS:       cfg_rows    = value[ROW_W-1:0];
      REG_LINE_PITCH: cfg_pitch   = value[PITCH_W-1:0];
      default: ;
    endcase
    // read back
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    seen = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (seen !== value) note_mismatch("register read back", seen, value);
  endtask

  task automatic run_phase(input int cols, input int rws, input int pitch,
                           input int idle, input int stall, input int n, input bit squeeze);
    wait_idle();
    reg_write(REG_COLUMNS, PDATA_W'(cols));
    reg_write(REG_ROWS, PDATA_W'(rws));
    reg_write(REG_LINE_PITCH, PDATA_W'(pitch));
    idle_pct  = idle;
    stall_pct = stall;
    @(posedge clk_i);
    if (squeeze) stall_kick = ~stall_kick;
    queue_random(n);
  endtask

  initial begin
    rst_ni                = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    char_bus.valid        = 1'b0;
    char_bus.action       = ACT_CHAR;
    char_bus.char_code    = '0;
    char_bus.pixel_color  = '0;
    char_bus.font_address = '0;
    char_bus.font_byte    = '0;
    row_bus.ready         = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: top glyph, a stray byte at address zero, colors and controls
    load_glyph(8'hFF);
    queue_font('0, '0);
    queue_char(8'hFF, 8'h00);
    queue_char(8'hFF, 8'hFF);
    queue_char(CH_RETURN, 8'h00);
    queue_char(8'hFF, 8'h5A);
    queue_char(CH_NEWLINE, 8'hFF);
    queue_char(8'hFF, 8'hA5);
    queue_char(CH_NEWLINE, 8'h00);
    queue_char(CH_RETURN, 8'hFF);

    run_phase(127, 31, 1023, 0, 0, 40, 1'b0);
    // small screen: cursor left beyond the new limits
    run_phase(1, 1, 1, 46, 0, 40, 1'b0);
    run_phase(5, 3, 45, 0, 46, 40, 1'b1);
    run_phase(2, 2, $urandom_range(1023, 1), 11, 11, 40, 1'b0);
    // zero registers act as one
    run_phase(0, 0, 0, 0, 0, 30, 1'b0);
    run_phase($urandom_range(127, 1), $urandom_range(31, 1), $urandom_range(1023, 1),
              11, 11, 40, 1'b0);

    wait_idle();
    if (mismatches == 0 && rows_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/tcgr_pkg.sv
rtl/core/tcgr_if.sv
rtl/core/tcgr_ctrl.sv
rtl/core/tcgr_dp.sv
rtl/core/text_cursor_glyph_renderer.sv
tb/sv/text_cursor_glyph_renderer_test.sv
